@@ hdl/tmsr_pkg.sv @@
// Shared types, constants and level tables of the two-motor speed regulator.
package tmsr_pkg;

  localparam int MotorCount  = 2;
  localparam int SpeedLevels = 6;

  localparam int DutyW   = 8;
  localparam int CountW  = 16;
  localparam int TargetW = 6;
  localparam int LevelW  = 3;
  localparam int DirW    = 2;
  localparam int RegW    = 8;
  localparam int RegIdxW = 3;

  localparam logic [DutyW-1:0] DutyCeiling = 8'd255;
  localparam logic [LevelW-1:0] LevelMax = LevelW'(SpeedLevels - 1);

  // Input command codes
  typedef enum logic [1:0] {
    CMD_PULSE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_MOVE  = 2'd2
  } cmd_e;

  // Drive direction codes
  typedef enum logic [DirW-1:0] {
    DIR_STOP    = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2
  } dir_e;

  // Configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_SMALL_LIMIT  = 3'd0,
    REG_MEDIUM_LIMIT = 3'd1,
    REG_STEP_SMALL   = 3'd2,
    REG_STEP_MEDIUM  = 3'd3,
    REG_STEP_LARGE   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [RegW-1:0] small_limit;
    logic [RegW-1:0] medium_limit;
    logic [RegW-1:0] step_small;
    logic [RegW-1:0] step_medium;
    logic [RegW-1:0] step_large;
  } cfg_t;

  // Per-motor update request for one item leaving the input register
  typedef struct packed {
    logic              advance;
    logic              hit;
    logic [1:0]        cmd;
    logic [DirW-1:0]   direction;
    logic [LevelW-1:0] level;
  } motor_ctl_t;

  // Target speed of each level; levels past the table repeat the last entry
  function automatic logic [TargetW-1:0] level_speed(input logic [LevelW-1:0] lvl);
    logic [TargetW-1:0] spd;
    case (lvl)
      3'd0:    spd = 6'd0;
      3'd1:    spd = 6'd10;
      3'd2:    spd = 6'd20;
      3'd3:    spd = 6'd30;
      3'd4:    spd = 6'd40;
      default: spd = 6'd50;
    endcase
    return spd;
  endfunction

  // Starting duty of each level
  function automatic logic [DutyW-1:0] level_duty(input logic [LevelW-1:0] lvl);
    logic [DutyW-1:0] duty;
    case (lvl)
      3'd0:    duty = 8'd0;
      3'd1:    duty = 8'd50;
      3'd2:    duty = 8'd80;
      3'd3:    duty = 8'd100;
      3'd4:    duty = 8'd150;
      default: duty = 8'd220;
    endcase
    return duty;
  endfunction

endpackage

@@ hdl/tmsr_motor.sv @@
// Per-motor state: pulse counter, speed measurement and duty regulation.
module tmsr_motor import tmsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  motor_ctl_t         ctl_i,
  input  cfg_t               cfg_i,
  output logic [DutyW-1:0]   duty_o,
  output logic [DirW-1:0]    dir_o,
  output logic [CountW-1:0]  speed_o
);

  logic [CountW-1:0]  count_q, count_d;
  logic [CountW-1:0]  prev_q, prev_d;
  logic [CountW-1:0]  speed_q, speed_d;
  logic [TargetW-1:0] target_q, target_d;
  logic [DutyW-1:0]   duty_q, duty_d;
  logic [DirW-1:0]    dir_q, dir_d;

  logic [CountW-1:0]  speed_new;
  logic [CountW:0]    err;
  logic [CountW:0]    mag;
  logic [RegW-1:0]    step;
  logic [DutyW:0]     duty_sum;
  logic [DutyW-1:0]   duty_reg;
  logic [LevelW-1:0]  lvl_sat;
  logic               dir_ok;

  // Measure speed and pick the regulation step from the error size
  always_comb begin
    speed_new = count_q - prev_q;
    err       = {1'b0, speed_new} - {{(CountW + 1 - TargetW){1'b0}}, target_q};
    mag       = err[CountW] ? (~err + 1'b1) : err;
    if (mag < {{(CountW + 1 - RegW){1'b0}}, cfg_i.small_limit}) begin
      step = cfg_i.step_small;
    end else if (mag < {{(CountW + 1 - RegW){1'b0}}, cfg_i.medium_limit}) begin
      step = cfg_i.step_medium;
    end else begin
      step = cfg_i.step_large;
    end
    duty_sum = {1'b0, duty_q} + {1'b0, step};
    // Raise while slow and below the ceiling, otherwise lower with a floor at zero
    if (err[CountW]) begin
      duty_reg = (duty_sum < {1'b0, DutyCeiling}) ? duty_sum[DutyW-1:0] : duty_q;
    end else begin
      duty_reg = (duty_q > step) ? (duty_q - step) : '0;
    end
  end

  assign lvl_sat = (ctl_i.level > LevelMax) ? LevelMax : ctl_i.level;
  assign dir_ok  = (ctl_i.direction == DIR_STOP) || (ctl_i.direction == DIR_FORWARD) ||
                   (ctl_i.direction == DIR_REVERSE);

  // Next state for the item leaving the input register
  always_comb begin
    count_d  = count_q;
    prev_d   = prev_q;
    speed_d  = speed_q;
    target_d = target_q;
    duty_d   = duty_q;
    dir_d    = dir_q;
    if (ctl_i.advance) begin
      case (cmd_e'(ctl_i.cmd))
        CMD_PULSE: begin
          if (ctl_i.hit) begin
            count_d = count_q + 1'b1;
          end
        end
        CMD_TICK: begin
          speed_d = speed_new;
          prev_d  = count_q;
          duty_d  = duty_reg;
        end
        CMD_MOVE: begin
          if (ctl_i.hit && dir_ok) begin
            dir_d    = ctl_i.direction;
            target_d = level_speed(lvl_sat);
            duty_d   = level_duty(lvl_sat);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      prev_q   <= '0;
      speed_q  <= '0;
      target_q <= '0;
      duty_q   <= '0;
      dir_q    <= DIR_STOP;
    end else begin
      count_q  <= count_d;
      prev_q   <= prev_d;
      speed_q  <= speed_d;
      target_q <= target_d;
      duty_q   <= duty_d;
      dir_q    <= dir_d;
    end
  end

  assign duty_o  = duty_q;
  assign dir_o   = dir_q;
  assign speed_o = speed_q;

endmodule

@@ hdl/two_motor_encoder_speed_regulator.sv @@
// Two-motor speed regulator: one item per cycle through an input register into
// the motor state, which doubles as the result register. An accepted item waits
// in the input register until the result side is free and then updates the
// motor state, where its result is shown; one item a cycle is sustained
// while out_ready_i stays high. The input register keeps taking one more item while
// a result waits. Encoder pulses, 100 ms ticks and move commands share the input
// channel; each item yields one result with both motors' duty, direction and last
// measured speed. Configuration writes are always taken (cfg_ready_o is tied high),
// take effect at once, and should only be made while the block is idle.
module two_motor_encoder_speed_regulator import tmsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic                motor_i,
  input  logic [DirW-1:0]     direction_i,
  input  logic [LevelW-1:0]   speed_level_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DutyW-1:0]    left_pwm_o,
  output logic [DutyW-1:0]    right_pwm_o,
  output logic [DirW-1:0]     left_direction_o,
  output logic [DirW-1:0]     right_direction_o,
  output logic [CountW-1:0]   left_speed_o,
  output logic [CountW-1:0]   right_speed_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [RegIdxW-1:0]  cfg_index_i,
  input  logic [RegW-1:0]     cfg_data_i
);

  cfg_t cfg_q, cfg_d;

  logic              in_valid_q, in_valid_d;
  logic [1:0]        cmd_q;
  logic              motor_q;
  logic [DirW-1:0]   direction_q;
  logic [LevelW-1:0] level_q;
  logic              out_valid_q, out_valid_d;
  logic              in_xfer;
  logic              advance;

  logic [DutyW-1:0]  duty   [MotorCount];
  logic [DirW-1:0]   dir    [MotorCount];
  logic [CountW-1:0] speed  [MotorCount];

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SMALL_LIMIT:  cfg_d.small_limit  = cfg_data_i;
        REG_MEDIUM_LIMIT: cfg_d.medium_limit = cfg_data_i;
        REG_STEP_SMALL:   cfg_d.step_small   = cfg_data_i;
        REG_STEP_MEDIUM:  cfg_d.step_medium  = cfg_data_i;
        REG_STEP_LARGE:   cfg_d.step_large   = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.small_limit  <= 8'd5;
      cfg_q.medium_limit <= 8'd10;
      cfg_q.step_small   <= 8'd1;
      cfg_q.step_medium  <= 8'd2;
      cfg_q.step_large   <= 8'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Handshake: advance the held item when the result side is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the input payload of each transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q       <= cmd_i;
      motor_q     <= motor_i;
      direction_q <= direction_i;
      level_q     <= speed_level_i;
    end
  end

  // One state slice per motor
  for (genvar k = 0; k < MotorCount; k++) begin : g_motor
    motor_ctl_t ctl;
    assign ctl.advance   = advance;
    assign ctl.hit       = (motor_q == 1'(k));
    assign ctl.cmd       = cmd_q;
    assign ctl.direction = direction_q;
    assign ctl.level     = level_q;

    tmsr_motor u_motor (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .cfg_i   (cfg_q),
      .duty_o  (duty[k]),
      .dir_o   (dir[k]),
      .speed_o (speed[k])
    );
  end

  assign out_valid_o       = out_valid_q;
  assign left_pwm_o        = duty[0];
  assign right_pwm_o       = duty[1];
  assign left_direction_o  = dir[0];
  assign right_direction_o = dir[1];
  assign left_speed_o      = speed[0];
  assign right_speed_o     = speed[1];

endmodule

@@ hdl/tmsr_checker.sv @@
// Port-level checks of the two-motor speed regulator, bound to the top level.
module tmsr_checker import tmsr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [DutyW-1:0]   left_pwm_o,
  input logic [DutyW-1:0]   right_pwm_o,
  input logic [DirW-1:0]    left_direction_o,
  input logic [DirW-1:0]    right_direction_o,
  input logic [CountW-1:0]  left_speed_o,
  input logic [CountW-1:0]  right_speed_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(left_pwm_o) && $stable(right_pwm_o) &&
      $stable(left_speed_o) && $stable(right_speed_o))
    else $error("result payload changed while stalled");

  // Input backpressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // Motor state only moves together with a new result
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> $stable(left_pwm_o) && $stable(right_pwm_o) &&
      $stable(left_direction_o) && $stable(right_direction_o) &&
      $stable(left_speed_o) && $stable(right_speed_o))
    else $error("motor state changed without a result");

  // An invalid direction never reaches the drive
  a_dir_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_direction_o != 2'd3 && right_direction_o != 2'd3)
    else $error("illegal drive direction");

endmodule

bind two_motor_encoder_speed_regulator tmsr_checker u_tmsr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .left_pwm_o        (left_pwm_o),
  .right_pwm_o       (right_pwm_o),
  .left_direction_o  (left_direction_o),
  .right_direction_o (right_direction_o),
  .left_speed_o      (left_speed_o),
  .right_speed_o     (right_speed_o)
);

@@ verif/speed_regulator_checker.sv @@
// Checker for the two-motor speed regulator: predicts every result and compares it.
module speed_regulator_checker import tmsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          cmd_i,
  input  logic                motor_i,
  input  logic [DirW-1:0]     direction_i,
  input  logic [LevelW-1:0]   speed_level_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [DutyW-1:0]    left_pwm_i,
  input  logic [DutyW-1:0]    right_pwm_i,
  input  logic [DirW-1:0]     left_direction_i,
  input  logic [DirW-1:0]     right_direction_i,
  input  logic [CountW-1:0]   left_speed_i,
  input  logic [CountW-1:0]   right_speed_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [RegIdxW-1:0]  cfg_index_i,
  input  logic [RegW-1:0]     cfg_data_i,
  input  logic                run_done_i,
  output int                  fail_count_o
);

  // Level tables, lowest level in the lowest slice
  localparam logic [5:0][TargetW-1:0] LevelTarget =
    {6'd50, 6'd40, 6'd30, 6'd20, 6'd10, 6'd0};
  localparam logic [5:0][DutyW-1:0] LevelStartDuty =
    {8'd220, 8'd150, 8'd100, 8'd80, 8'd50, 8'd0};

  typedef struct packed {
    logic [DutyW-1:0]  left_pwm;
    logic [DutyW-1:0]  right_pwm;
    logic [DirW-1:0]   left_dir;
    logic [DirW-1:0]   right_dir;
    logic [CountW-1:0] left_speed;
    logic [CountW-1:0] right_speed;
  } drive_report_t;

  cfg_t               regulator_cfg;
  logic [CountW-1:0]  pulses      [MotorCount];
  logic [CountW-1:0]  last_pulses [MotorCount];
  logic [CountW-1:0]  speed       [MotorCount];
  logic [TargetW-1:0] target      [MotorCount];
  logic [DutyW-1:0]   duty        [MotorCount];
  logic [DirW-1:0]    heading     [MotorCount];
  drive_report_t      expected_reports[$];
  int                 mismatches;
  bit                 leftovers_checked;

  assign fail_count_o = mismatches;

  // Step one duty toward its target; the step size follows the error magnitude
  function automatic logic [DutyW-1:0] regulated_duty(input logic [CountW-1:0] spd,
                                                      input logic [TargetW-1:0] tgt,
                                                      input logic [DutyW-1:0] cur,
                                                      input cfg_t c);
    int err;
    int mag;
    int step;
    int next_duty;
    err = int'(spd) - int'(tgt);
    mag = (err < 0) ? -err : err;
    if (mag < int'(c.small_limit)) begin
      step = int'(c.step_small);
    end else if (mag < int'(c.medium_limit)) begin
      step = int'(c.step_medium);
    end else begin
      step = int'(c.step_large);
    end
    next_duty = int'(cur);
    if (err < 0) begin
      if (next_duty + step < int'(DutyCeiling)) next_duty = next_duty + step;
    end else if (next_duty > step) begin
      next_duty = next_duty - step;
    end else begin
      next_duty = 0;
    end
    return next_duty[DutyW-1:0];
  endfunction

  // Advance the motor state by one item and queue the report it should produce
  task automatic advance_drive_state(input logic [1:0] cmd, input logic mot,
                                     input logic [DirW-1:0] dir,
                                     input logic [LevelW-1:0] lvl);
    logic [LevelW-1:0] level;
    drive_report_t     report;
    case (cmd)
      CMD_PULSE: pulses[mot] = pulses[mot] + 1'b1;
      CMD_TICK: begin
        for (int k = 0; k < MotorCount; k++) begin
          speed[k] = pulses[k] - last_pulses[k];
          last_pulses[k] = pulses[k];
        end
        for (int k = 0; k < MotorCount; k++) begin
          duty[k] = regulated_duty(speed[k], target[k], duty[k], regulator_cfg);
        end
      end
      CMD_MOVE: begin
        // Drop a move with an invalid direction; saturate the level
        if (dir == DIR_STOP || dir == DIR_FORWARD || dir == DIR_REVERSE) begin
          level = (lvl > LevelMax) ? LevelMax : lvl;
          heading[mot] = dir;
          target[mot] = LevelTarget[level];
          duty[mot] = LevelStartDuty[level];
        end
      end
      default: ;
    endcase
    report.left_pwm    = duty[0];
    report.right_pwm   = duty[1];
    report.left_dir    = heading[0];
    report.right_dir   = heading[1];
    report.left_speed  = speed[0];
    report.right_speed = speed[1];
    expected_reports.push_back(report);
  endtask

  task automatic check_field(input string name, input int expected_val, input int actual_val);
    if (expected_val != actual_val) begin
      $error("%s: expected %0d, actual %0d", name, expected_val, actual_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drive_report_t oldest;
    if (!rst_ni) begin
      regulator_cfg = '{small_limit: 8'd5, medium_limit: 8'd10, step_small: 8'd1,
                        step_medium: 8'd2, step_large: 8'd5};
      for (int k = 0; k < MotorCount; k++) begin
        pulses[k] = '0;
        last_pulses[k] = '0;
        speed[k] = '0;
        target[k] = '0;
        duty[k] = '0;
        heading[k] = DIR_STOP;
      end
      expected_reports.delete();
      mismatches = 0;
      leftovers_checked = 1'b0;
    end else begin
      // Compare a result transfer against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer with no prediction waiting");
          mismatches++;
        end else begin
          oldest = expected_reports.pop_front();
          check_field("left_pwm", oldest.left_pwm, left_pwm_i);
          check_field("right_pwm", oldest.right_pwm, right_pwm_i);
          check_field("left_direction", oldest.left_dir, left_direction_i);
          check_field("right_direction", oldest.right_dir, right_direction_i);
          check_field("left_speed", oldest.left_speed, left_speed_i);
          check_field("right_speed", oldest.right_speed, right_speed_i);
        end
      end
      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SMALL_LIMIT:  regulator_cfg.small_limit  = cfg_data_i;
          REG_MEDIUM_LIMIT: regulator_cfg.medium_limit = cfg_data_i;
          REG_STEP_SMALL:   regulator_cfg.step_small   = cfg_data_i;
          REG_STEP_MEDIUM:  regulator_cfg.step_medium  = cfg_data_i;
          REG_STEP_LARGE:   regulator_cfg.step_large   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        advance_drive_state(cmd_i, motor_i, direction_i, speed_level_i);
      end
      // Count predictions never matched by a result
      if (run_done_i && !leftovers_checked) begin
        if (expected_reports.size() != 0) begin
          $error("%0d predicted results never arrived", expected_reports.size());
          mismatches += expected_reports.size();
        end
        leftovers_checked = 1'b1;
      end
    end
  end

endmodule

@@ verif/two_motor_encoder_speed_regulator_test.sv @@
// Stimulus and verdict for the two-motor speed regulator testbench.
module two_motor_encoder_speed_regulator_test;
  import tmsr_pkg::*;

  localparam logic [1:0]      CmdUnused  = 2'd3;
  localparam logic [DirW-1:0] DirInvalid = 2'd3;

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_COIN, READY_SPARSE} stall_mode_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          cmd = '0;
  logic                motor = 1'b0;
  logic [DirW-1:0]     direction = '0;
  logic [LevelW-1:0]   speed_level = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DutyW-1:0]    left_pwm;
  logic [DutyW-1:0]    right_pwm;
  logic [DirW-1:0]     left_direction;
  logic [DirW-1:0]     right_direction;
  logic [CountW-1:0]   left_speed;
  logic [CountW-1:0]   right_speed;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [RegIdxW-1:0]  cfg_index = '0;
  logic [RegW-1:0]     cfg_data = '0;
  logic                run_done = 1'b0;
  int                  fail_count;

  int          items_sent = 0;
  int          results_seen = 0;
  int          burst_left = 0;
  bit          gap_free = 1'b0;
  stall_mode_e stall_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          stall_phase = 0;

  always #5 clk = ~clk;

  two_motor_encoder_speed_regulator u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .cmd_i            (cmd),
    .motor_i          (motor),
    .direction_i      (direction),
    .speed_level_i    (speed_level),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .left_pwm_o       (left_pwm),
    .right_pwm_o      (right_pwm),
    .left_direction_o (left_direction),
    .right_direction_o(right_direction),
    .left_speed_o     (left_speed),
    .right_speed_o    (right_speed),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  speed_regulator_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .cmd_i            (cmd),
    .motor_i          (motor),
    .direction_i      (direction),
    .speed_level_i    (speed_level),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .left_pwm_i       (left_pwm),
    .right_pwm_i      (right_pwm),
    .left_direction_i (left_direction),
    .right_direction_i(right_direction),
    .left_speed_i     (left_speed),
    .right_speed_i    (right_speed),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .run_done_i       (run_done),
    .fail_count_o     (fail_count)
  );

  // Stall the result side in stretches of varying pressure
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 128);
    end
    mode_left--;
    stall_phase = (stall_phase + 1) % 3;
    case (stall_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      default:      out_ready <= (stall_phase == 0);
    endcase
  end

  // Count result transfers
  always @(posedge clk) begin
    if (out_valid && out_ready) results_seen <= results_seen + 1;
  end

  // Offer one item and hold it until the transfer; gaps fall between bursts
  task automatic send_item(input logic [1:0] c, input logic m, input logic [DirW-1:0] d,
                           input logic [LevelW-1:0] l);
    if (burst_left == 0 && !gap_free) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid    <= 1'b1;
    cmd         <= c;
    motor       <= m;
    direction   <= d;
    speed_level <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_pulse(input logic m);
    send_item(CMD_PULSE, m, DirW'($urandom), LevelW'($urandom));
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 1'($urandom), DirW'($urandom), LevelW'($urandom));
  endtask

  // Moves mostly valid, now and then with an invalid direction
  task automatic send_random_move();
    logic [DirW-1:0] d;
    d = ($urandom_range(0, 7) == 0) ? DirInvalid : DirW'($urandom_range(0, 2));
    send_item(CMD_MOVE, 1'($urandom), d, LevelW'($urandom_range(0, 7)));
  endtask

  // One sample period: a random number of pulses per motor, some noise, then a tick
  task automatic send_sample_period();
    int left_n;
    int right_n;
    int roll;
    left_n  = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 12) : $urandom_range(0, 55);
    right_n = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 12) : $urandom_range(0, 55);
    while (left_n + right_n > 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 7) begin
        send_random_move();
      end else if (roll < 9) begin
        send_item(CmdUnused, 1'($urandom), DirW'($urandom), LevelW'($urandom));
      end else if (roll < 10) begin
        send_tick();
      end else if (left_n > 0 && (right_n == 0 || $urandom_range(0, 1) == 1)) begin
        send_pulse(1'b0);
        left_n--;
      end else begin
        send_pulse(1'b1);
        right_n--;
      end
    end
    send_tick();
  endtask

  task automatic run_random(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) send_sample_period();
  endtask

  // Drop valid and hold until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all five registers in one back-to-back sequence
  task automatic write_settings(input cfg_t s);
    reg_idx_e idx;
    for (int i = 0; i <= int'(REG_STEP_LARGE); i++) begin
      idx = reg_idx_e'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_SMALL_LIMIT:  cfg_data <= s.small_limit;
        REG_MEDIUM_LIMIT: cfg_data <= s.medium_limit;
        REG_STEP_SMALL:   cfg_data <= s.step_small;
        REG_STEP_MEDIUM:  cfg_data <= s.step_medium;
        default:          cfg_data <= s.step_large;
      endcase
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    cfg_t settings [6];
    settings[0] = '{small_limit: 8'd255, medium_limit: 8'd255, step_small: 8'd255,
                    step_medium: 8'd0, step_large: 8'd128};
    settings[1] = '{small_limit: 8'd0, medium_limit: 8'd0, step_small: 8'd0,
                    step_medium: 8'd7, step_large: 8'd255};
    settings[2] = '{small_limit: 8'd20, medium_limit: 8'd3, step_small: 8'd3,
                    step_medium: 8'd7, step_large: 8'd11};
    settings[3] = '{small_limit: 8'd0, medium_limit: 8'd255, step_small: 8'd1,
                    step_medium: 8'd254, step_large: 8'd0};
    settings[4] = '{small_limit: RegW'($urandom_range(0, 30)),
                    medium_limit: RegW'($urandom_range(0, 60)),
                    step_small: RegW'($urandom), step_medium: RegW'($urandom),
                    step_large: RegW'($urandom)};
    settings[5] = '{small_limit: 8'd5, medium_limit: 8'd10, step_small: 8'd1,
                    step_medium: 8'd2, step_large: 8'd5};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, every direction, level saturation, stop with duty,
    // invalid direction, unused command, pulses on both motors and regulation
    send_tick();
    send_item(CMD_MOVE, 1'b0, DIR_FORWARD, 3'd0);
    send_item(CMD_MOVE, 1'b1, DIR_REVERSE, 3'd5);
    send_item(CMD_MOVE, 1'b0, DIR_FORWARD, 3'd7);
    send_item(CMD_MOVE, 1'b1, DIR_STOP, 3'd3);
    send_item(CMD_MOVE, 1'b0, DirInvalid, 3'd2);
    send_item(CmdUnused, 1'b1, DirInvalid, 3'd7);
    repeat (3) send_pulse(1'b0);
    send_pulse(1'b1);
    send_tick();
    send_tick();
    send_item(CMD_MOVE, 1'b1, DIR_FORWARD, 3'd6);
    send_item(CMD_MOVE, 1'b0, DIR_REVERSE, 3'd1);
    repeat (7) send_pulse(1'b1);
    send_tick();
    send_tick();

    run_random(60);

    // Random phases under each register setting, extremes first
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_settings(settings[p]);
      run_random(60);
    end

    // Back-to-back pulses with no gaps, then a tick to measure them
    wait_idle();
    gap_free = 1'b1;
    send_tick();
    repeat (30) send_pulse(1'b0);
    send_tick();
    gap_free = 1'b0;

    wait_idle();
    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Bound the run in case a handshake never completes
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
